// ===== rtl/stt_pkg.sv =====
// shared token kinds, keyword tables and character classes for the source text tokenizer
package stt_pkg;

	localparam int POSITION_BITS_DEF = 16;
	localparam int KW_COUNT          = 8;
	localparam int KIND_W            = 5;
	localparam int OUT_W             = 16;

	localparam logic [KIND_W-1:0] K_NUMBER    = 5'd0;
	localparam logic [KIND_W-1:0] K_STRING    = 5'd1;
	localparam logic [KIND_W-1:0] K_PLUS      = 5'd2;
	localparam logic [KIND_W-1:0] K_MINUS     = 5'd3;
	localparam logic [KIND_W-1:0] K_STAR      = 5'd4;
	localparam logic [KIND_W-1:0] K_SLASH     = 5'd5;
	localparam logic [KIND_W-1:0] K_LPAREN    = 5'd6;
	localparam logic [KIND_W-1:0] K_RPAREN    = 5'd7;
	localparam logic [KIND_W-1:0] K_LBRACE    = 5'd8;
	localparam logic [KIND_W-1:0] K_RBRACE    = 5'd9;
	localparam logic [KIND_W-1:0] K_LBRACK    = 5'd10;
	localparam logic [KIND_W-1:0] K_RBRACK    = 5'd11;
	localparam logic [KIND_W-1:0] K_COMMA     = 5'd12;
	localparam logic [KIND_W-1:0] K_GREATER   = 5'd13;
	localparam logic [KIND_W-1:0] K_LESS      = 5'd14;
	localparam logic [KIND_W-1:0] K_EQEQ      = 5'd15;
	localparam logic [KIND_W-1:0] K_IDENT     = 5'd16;
	localparam logic [KIND_W-1:0] K_EQUALS    = 5'd17;
	localparam logic [KIND_W-1:0] K_SEMICOLON = 5'd18;
	localparam logic [KIND_W-1:0] K_PRINT     = 5'd19;
	localparam logic [KIND_W-1:0] K_IF        = 5'd20;
	localparam logic [KIND_W-1:0] K_ELSE      = 5'd21;
	localparam logic [KIND_W-1:0] K_WHILE     = 5'd22;
	localparam logic [KIND_W-1:0] K_INPUT     = 5'd23;
	localparam logic [KIND_W-1:0] K_CLEAR     = 5'd24;
	localparam logic [KIND_W-1:0] K_FUNC      = 5'd25;
	localparam logic [KIND_W-1:0] K_RETURN    = 5'd26;
	localparam logic [KIND_W-1:0] K_EOF       = 5'd27;

	localparam logic [7:0] CH_EQUALS = 8'h3D;
	localparam logic [7:0] CH_QUOTE  = 8'h22;

	// one queued token record
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [OUT_W-1:0]  start;
		logic [OUT_W-1:0]  len;
		logic              last;
	} tok_t;

	// keyword text, first character in the top byte, zero padded
	function automatic logic [47:0] kw_text(input logic [2:0] idx);
		logic [47:0] t;
		case (idx)
			3'd0: t = {"print", 8'h00};
			3'd1: t = {"input", 8'h00};
			3'd2: t = {"clear", 8'h00};
			3'd3: t = {"if", 32'h0};
			3'd4: t = {"else", 16'h0};
			3'd5: t = {"while", 8'h00};
			3'd6: t = {"func", 16'h0};
			3'd7: t = "return";
			default: t = '0;
		endcase
		return t;
	endfunction

	function automatic logic [7:0] kw_char(input logic [2:0] idx, input logic [2:0] pos);
		logic [47:0] t;
		logic [7:0]  ch;
		t = kw_text(idx);
		case (pos)
			3'd0: ch = t[47:40];
			3'd1: ch = t[39:32];
			3'd2: ch = t[31:24];
			3'd3: ch = t[23:16];
			3'd4: ch = t[15:8];
			3'd5: ch = t[7:0];
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [2:0] kw_len(input logic [2:0] idx);
		logic [2:0] n;
		case (idx)
			3'd3: n = 3'd2;
			3'd4: n = 3'd4;
			3'd6: n = 3'd4;
			3'd7: n = 3'd6;
			default: n = 3'd5;
		endcase
		return n;
	endfunction

	function automatic logic [KIND_W-1:0] kw_kind(input logic [2:0] idx);
		logic [KIND_W-1:0] k;
		case (idx)
			3'd0: k = K_PRINT;
			3'd1: k = K_INPUT;
			3'd2: k = K_CLEAR;
			3'd3: k = K_IF;
			3'd4: k = K_ELSE;
			3'd5: k = K_WHILE;
			3'd6: k = K_FUNC;
			3'd7: k = K_RETURN;
			default: k = K_IDENT;
		endcase
		return k;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	// punctuation that forms a token on its own: {hit, kind}
	function automatic logic [KIND_W:0] single_kind(input logic [7:0] c);
		logic [KIND_W:0] r;
		case (c)
			8'h2B: r = {1'b1, K_PLUS};
			8'h2D: r = {1'b1, K_MINUS};
			8'h2A: r = {1'b1, K_STAR};
			8'h2F: r = {1'b1, K_SLASH};
			8'h28: r = {1'b1, K_LPAREN};
			8'h29: r = {1'b1, K_RPAREN};
			8'h7B: r = {1'b1, K_LBRACE};
			8'h7D: r = {1'b1, K_RBRACE};
			8'h5B: r = {1'b1, K_LBRACK};
			8'h5D: r = {1'b1, K_RBRACK};
			8'h2C: r = {1'b1, K_COMMA};
			8'h3E: r = {1'b1, K_GREATER};
			8'h3C: r = {1'b1, K_LESS};
			8'h3B: r = {1'b1, K_SEMICOLON};
			default: r = {1'b0, K_IDENT};
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/source_text_tokenizer.sv =====
// source text tokenizer: byte stream in, token records out
//
// Takes one source byte per transaction on the src channel and returns token records
// (kind, start offset, length) on the tok channel; token text is never copied, only
// located. A byte is held in an input register, where a short piece of logic
// advances the lexer mode and writes the zero, one or two records that the byte causes
// into an 8-entry result queue; a record passes the input register and then the queue before it can leave.
// The block takes one byte every cycle as long as the tok side drains one record per
// cycle and bytes average no more than one record each; the queue absorbs bytes that
// end one token and emit a second (for example "abc+"), and src_stall rises only when
// the queue could not hold two more records for the byte in flight and the next one.
// An end_of_source transaction flushes any pending token, emits the end-of-file token
// and returns the lexer to offset zero. Positions and lengths saturate at all ones.
module source_text_tokenizer
	import stt_pkg::*;
#(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_stall,
	input  logic [7:0]        char_code,
	input  logic              end_of_source,
	output logic              tok_valid,
	input  logic              tok_stall,
	output logic [KIND_W-1:0] token_kind,
	output logic [OUT_W-1:0]  start_pos,
	output logic [OUT_W-1:0]  token_length,
	output logic              last_of_run
);

	localparam int P      = POSITION_BITS;
	localparam int DEPTH  = 8;
	localparam int PTR_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_EQ,
		MODE_STR,
		MODE_NUM,
		MODE_WORD
	} mode_t;

	// input register
	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        eos_s1;

	// lexer state
	mode_t               mode_q, mode_d;
	logic [P-1:0]        rp_q, rp_d;
	logic [P-1:0]        ts_q, ts_d;
	logic [KW_COUNT-1:0] cand_q, cand_d;

	// result queue
	tok_t             fifo_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	// results of the byte in the input register
	tok_t       r0, r1, push_a, push_b;
	logic       r0_v, r1_v;
	logic [1:0] n_push;
	logic       pop;
	logic       idle_go;

	logic [P-1:0]        rp_inc, len_cur;
	logic [KIND_W-1:0]   word_kind;
	logic [KIND_W:0]     single;
	logic [KW_COUNT-1:0] cand_cont, cand_first;

	// clamp a position to the 16-bit output field
	function automatic logic [OUT_W-1:0] clamp_out(input logic [P-1:0] v);
		logic [31:0] ext;
		ext = 32'(v);
		return (|ext[31:OUT_W]) ? '1 : ext[OUT_W-1:0];
	endfunction

	// keep keywords whose character at index k equals c
	function automatic logic [KW_COUNT-1:0] match_kw(input logic [KW_COUNT-1:0] base,
			input logic [P-1:0] k, input logic [7:0] c);
		logic [KW_COUNT-1:0] m;
		m = base;
		for (int i = 0; i < KW_COUNT; i++) begin
			if (k >= P'(kw_len(3'(i))) || kw_char(3'(i), k[2:0]) != c) begin
				m[i] = 1'b0;
			end
		end
		return m;
	endfunction

	// saturating next offset and length of the pending token
	assign rp_inc  = (&rp_q) ? rp_q : rp_q + P'(1);
	assign len_cur = (rp_q >= ts_q) ? rp_q - ts_q : '0;

	assign cand_cont  = match_kw(cand_q, len_cur, char_s1);
	assign cand_first = match_kw('1, '0, char_s1);
	assign single     = single_kind(char_s1);

	// first surviving candidate of full length names a keyword
	always_comb begin
		word_kind = K_IDENT;
		for (int i = KW_COUNT - 1; i >= 0; i--) begin
			if (cand_q[i] && len_cur == P'(kw_len(3'(i)))) begin
				word_kind = kw_kind(3'(i));
			end
		end
	end

	// mode step: r0 is the flushed pending token, r1 the token of a byte seen fresh or the end-of-file token
	always_comb begin
		mode_d  = mode_q;
		rp_d    = rp_q;
		ts_d    = ts_q;
		cand_d  = cand_q;
		r0_v    = 1'b0;
		r1_v    = 1'b0;
		r0      = '0;
		r1      = '0;
		idle_go = 1'b0;
		if (valid_s1) begin
			if (eos_s1) begin
				r0.start = clamp_out(ts_q);
				r0.len   = clamp_out(len_cur);
				case (mode_q)
					MODE_EQ: begin
						r0_v = 1'b1; r0.kind = K_EQUALS; r0.len = OUT_W'(1);
					end
					MODE_STR: begin
						r0_v = 1'b1; r0.kind = K_STRING;
					end
					MODE_NUM: begin
						r0_v = 1'b1; r0.kind = K_NUMBER;
					end
					MODE_WORD: begin
						r0_v = 1'b1; r0.kind = word_kind;
					end
					default: r0_v = 1'b0;
				endcase
				r1_v     = 1'b1;
				r1.kind  = K_EOF;
				r1.start = clamp_out(rp_q);
				r1.len   = '0;
				mode_d   = MODE_IDLE;
				rp_d     = '0;
				ts_d     = '0;
				cand_d   = '0;
			end else begin
				r0.start = clamp_out(ts_q);
				r0.len   = clamp_out(len_cur);
				case (mode_q)
					MODE_EQ: begin
						r0_v = 1'b1;
						if (char_s1 == CH_EQUALS) begin
							r0.kind = K_EQEQ;
							r0.len  = OUT_W'(2);
							mode_d  = MODE_IDLE;
						end else begin
							r0.kind = K_EQUALS;
							r0.len  = OUT_W'(1);
							idle_go = 1'b1;
						end
					end
					MODE_STR: begin
						if (char_s1 == CH_QUOTE) begin
							r0_v    = 1'b1;
							r0.kind = K_STRING;
							mode_d  = MODE_IDLE;
						end
					end
					MODE_NUM: begin
						if (!is_digit(char_s1)) begin
							r0_v    = 1'b1;
							r0.kind = K_NUMBER;
							idle_go = 1'b1;
						end
					end
					MODE_WORD: begin
						if (is_alpha(char_s1) || is_digit(char_s1)) begin
							cand_d = cand_cont;
						end else begin
							r0_v    = 1'b1;
							r0.kind = word_kind;
							cand_d  = '0;
							idle_go = 1'b1;
						end
					end
					default: idle_go = 1'b1;
				endcase

				// terminator or fresh byte handled as in the idle mode
				if (idle_go) begin
					mode_d = MODE_IDLE;
					if (is_space(char_s1)) begin
						mode_d = MODE_IDLE;
					end else if (single[KIND_W]) begin
						r1_v     = 1'b1;
						r1.kind  = single[KIND_W-1:0];
						r1.start = clamp_out(rp_q);
						r1.len   = OUT_W'(1);
					end else if (char_s1 == CH_EQUALS) begin
						mode_d = MODE_EQ;
						ts_d   = rp_q;
					end else if (char_s1 == CH_QUOTE) begin
						mode_d = MODE_STR;
						ts_d   = rp_inc;
					end else if (is_digit(char_s1)) begin
						mode_d = MODE_NUM;
						ts_d   = rp_q;
					end else if (is_alpha(char_s1)) begin
						mode_d = MODE_WORD;
						ts_d   = rp_q;
						cand_d = cand_first;
					end
				end
				rp_d = rp_inc;
			end
		end
	end

	// order records into queue slots and mark the last one of the byte
	always_comb begin
		push_a      = r0_v ? r0 : r1;
		push_a.last = !(r0_v && r1_v);
		push_b      = r1;
		push_b.last = 1'b1;
		n_push      = {1'b0, r0_v} + {1'b0, r1_v};
	end

	assign pop = tok_valid && !tok_stall;

	// room for two records of the byte in flight and two of the next one
	assign src_stall = (CNT_W'(count_q) + (valid_s1 ? CNT_W'(2) : CNT_W'(0)))
		> CNT_W'(DEPTH - 2);

	assign tok_valid    = count_q != '0;
	assign token_kind   = fifo_q[rd_ptr_q].kind;
	assign start_pos    = fifo_q[rd_ptr_q].start;
	assign token_length = fifo_q[rd_ptr_q].len;
	assign last_of_run  = fifo_q[rd_ptr_q].last;

	// control and lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= MODE_IDLE;
			rp_q     <= '0;
			ts_q     <= '0;
			cand_q   <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			valid_s1 <= src_valid && !src_stall;
			mode_q   <= mode_d;
			rp_q     <= rp_d;
			ts_q     <= ts_d;
			cand_q   <= cand_d;
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(n_push) - (pop ? CNT_W'(1) : CNT_W'(0));
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			char_s1 <= char_code;
			eos_s1  <= end_of_source;
		end
		if (n_push != 2'd0) begin
			fifo_q[wr_ptr_q] <= push_a;
		end
		if (n_push == 2'd2) begin
			fifo_q[wr_ptr_q + PTR_W'(1)] <= push_b;
		end
	end

endmodule

// ===== rtl/stt_checker.sv =====
// port-level checks for the source text tokenizer, bound to the top level
module stt_checker
	import stt_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              src_valid,
	input logic              src_stall,
	input logic [7:0]        char_code,
	input logic              end_of_source,
	input logic              tok_valid,
	input logic              tok_stall,
	input logic [KIND_W-1:0] token_kind,
	input logic [OUT_W-1:0]  start_pos,
	input logic [OUT_W-1:0]  token_length,
	input logic              last_of_run
);

	// a stalled record holds
	a_tok_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_stall |=> tok_valid && $stable(token_kind)
			&& $stable(start_pos) && $stable(token_length) && $stable(last_of_run))
		else $error("stalled token record changed");

	// end of file closes the run and carries no text
	a_eof_shape: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && token_kind == K_EOF |-> last_of_run && token_length == '0)
		else $error("end-of-file record malformed");

	// both records of one byte are queued together, so the second follows at once
	a_run_follows: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !tok_stall && !last_of_run |=> tok_valid)
		else $error("second record of a byte missing");

	// double equals always spans two bytes
	a_eqeq_len: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && token_kind == K_EQEQ |-> token_length == OUT_W'(2))
		else $error("double equals length wrong");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (.*);
